### sv/ptbr_pkg.sv
package ptbr_pkg;

    localparam int BYTE_W         = 8;
    localparam int ADDR_W         = 9;
    localparam int GROUP_LEN      = 8;
    localparam int SLOT_W         = 3;
    localparam int DEF_PANEL_COLS = 128;
    localparam int DEF_PANEL_ROWS = 32;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(GROUP_LEN - 1);

    // one 8x8 block handed from the collector to the emitter
    typedef struct packed {
        logic [GROUP_LEN-1:0][BYTE_W-1:0] bytes;
        logic [ADDR_W-1:0]                base;
        logic                             frame_end;
    } block_t;

endpackage

### sv/ptbr_if.sv
interface ptbr_in_if
    import ptbr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface ptbr_out_if
    import ptbr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] out_addr;
    logic [BYTE_W-1:0] out_byte;
    logic              group_last;
    logic              frame_last;

    modport source (output valid, output out_addr, output out_byte, output group_last,
                    output frame_last, input ready);
    modport sink   (input valid, input out_addr, input out_byte, input group_last,
                    input frame_last, output ready);
endinterface

### sv/ptbr_collect.sv
module ptbr_collect
    import ptbr_pkg::*;
#(
    parameter int PANEL_COLS = DEF_PANEL_COLS,
    parameter int PANEL_ROWS = DEF_PANEL_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    ptbr_in_if.sink     pix_in,
    output block_t      blk,
    output logic        blk_valid,
    input  logic        blk_ready
);

    localparam int ROW_PAGES = PANEL_ROWS / 8;
    localparam int COL_PAGES = PANEL_COLS / 8;
    localparam int GRP_W     = (ROW_PAGES > 1) ? $clog2(ROW_PAGES) : 1;
    localparam int PAGE_W    = (COL_PAGES > 1) ? $clog2(COL_PAGES) : 1;
    localparam logic [GRP_W-1:0]  GRP_LAST  = GRP_W'(ROW_PAGES - 1);
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(COL_PAGES - 1);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [GRP_W-1:0]  grp_reg, grp_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [BYTE_W-1:0] group_reg [GROUP_LEN-1];
    logic              accept;
    logic [GRP_W-1:0]  land_page;

    assign pix_in.ready = (slot_reg != SLOT_LAST) || blk_ready;
    assign accept       = pix_in.valid && pix_in.ready;
    assign blk_valid    = pix_in.valid && (slot_reg == SLOT_LAST);
    assign land_page    = GRP_LAST - grp_reg;

    always_comb
    begin
        for (int j = 0; j < GROUP_LEN - 1; j++)
        begin
            blk.bytes[j] = group_reg[j];
        end
        blk.bytes[GROUP_LEN-1] = pix_in.pixel_byte;
        blk.base = ADDR_W'(32'(page_reg) * 32'd8 + 32'(land_page) * 32'(PANEL_COLS));
        blk.frame_end = (grp_reg == GRP_LAST) && (page_reg == PAGE_LAST);
    end

    always_comb
    begin
        slot_next = slot_reg;
        grp_next  = grp_reg;
        page_next = page_reg;
        if (accept)
        begin
            slot_next = slot_reg + SLOT_W'(1);
            if (slot_reg == SLOT_LAST)
            begin
                if (grp_reg == GRP_LAST)
                begin
                    grp_next  = '0;
                    page_next = (page_reg == PAGE_LAST) ? '0 : page_reg + PAGE_W'(1);
                end
                else
                begin
                    grp_next = grp_reg + GRP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            grp_reg  <= '0;
            page_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            grp_reg  <= grp_next;
            page_reg <= page_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (slot_reg != SLOT_LAST))
        begin
            group_reg[slot_reg] <= pix_in.pixel_byte;
        end
    end

    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        grp_reg <= GRP_LAST)
        else $error("block index past end of page row");

    a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
        page_reg <= PAGE_LAST)
        else $error("page index past end of frame");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && blk.frame_end && (slot_reg == SLOT_LAST)
        |=> (slot_reg == '0) && (grp_reg == '0) && (page_reg == '0))
        else $error("frame counter did not wrap");

endmodule

### sv/ptbr_emit.sv
module ptbr_emit
    import ptbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  block_t      blk,
    input  logic        blk_valid,
    output logic        blk_ready,
    ptbr_out_if.source  pix_out
);

    block_t            blk_reg;
    logic              blk_valid_reg, blk_valid_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              group_last_reg;
    logic              frame_last_reg;
    logic              adv;
    logic              load;
    logic [BYTE_W-1:0] tr_byte;

    assign adv       = blk_valid_reg && (!out_valid_reg || pix_out.ready);
    assign blk_ready = !blk_valid_reg
                       || ((idx_reg == SLOT_LAST) && (!out_valid_reg || pix_out.ready));
    assign load      = blk_valid && blk_ready;

    // bit (7-j) of landscape byte n is bit n of block byte j
    always_comb
    begin
        for (int j = 0; j < GROUP_LEN; j++)
        begin
            tr_byte[GROUP_LEN-1-j] = blk_reg.bytes[j][idx_reg];
        end
    end

    always_comb
    begin
        idx_next       = adv ? idx_reg + SLOT_W'(1) : idx_reg;
        blk_valid_next = blk_valid_reg;
        if (load)
        begin
            blk_valid_next = 1'b1;
        end
        else if (adv && (idx_reg == SLOT_LAST))
        begin
            blk_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            blk_valid_reg <= blk_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            blk_reg <= blk;
        end
        if (adv)
        begin
            out_addr_reg   <= {blk_reg.base[ADDR_W-1:SLOT_W], idx_reg};
            out_byte_reg   <= tr_byte;
            group_last_reg <= (idx_reg == SLOT_LAST);
            frame_last_reg <= (idx_reg == SLOT_LAST) && blk_reg.frame_end;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.out_addr   = out_addr_reg;
    assign pix_out.out_byte   = out_byte_reg;
    assign pix_out.group_last = group_last_reg;
    assign pix_out.frame_last = frame_last_reg;

    a_frame_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_last_reg |-> group_last_reg)
        else $error("frame_last without group_last");

    a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && group_last_reg |-> (out_addr_reg[SLOT_W-1:0] == SLOT_LAST))
        else $error("group_last on wrong column");

    a_block_held: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (idx_reg != SLOT_LAST) |=> blk_valid_reg)
        else $error("block dropped before all words were sent");

    a_load_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (idx_reg == '0))
        else $error("new block started mid-group");

endmodule

### sv/page_tiled_bitmap_rotate_90_core.sv
// Portrait-to-landscape rotator for a 1-bit page-format frame buffer.
// pix_in takes one word per cycle while ready is high: a portrait buffer
// byte in buffer order. Every eight words form an 8x8 block; the eighth word
// hands the block to the emitter, which sends eight words on pix_out, one per
// cycle while pix_out is ready, each with its landscape address, in order of
// rising landscape column. group_last marks the eighth word of a block,
// frame_last the last word of the frame. The frame position wraps after
// PANEL_ROWS*PANEL_COLS/8 words. The emitter registers each block, and each
// result word is registered at the output before it is valid on pix_out.
// Throughput: one input word and one output word per cycle while pix_out is
// ready, set by the combinational transpose between the block register and the
// output register; the next block is collected while the current one is sent.
// When pix_out stalls, output words hold and pix_in keeps taking words
// until the eighth of the next block, which waits for the emitter.
// Reset clears the frame position and empties the emitter; no words are
// pending after reset and a new frame starts.
module page_tiled_bitmap_rotate_90_core
    import ptbr_pkg::*;
#(
    parameter int PANEL_COLS = DEF_PANEL_COLS,
    parameter int PANEL_ROWS = DEF_PANEL_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    ptbr_in_if.sink     pix_in,
    ptbr_out_if.source  pix_out
);

    block_t blk;
    logic   blk_valid;
    logic   blk_ready;

    ptbr_collect #(
        .PANEL_COLS (PANEL_COLS),
        .PANEL_ROWS (PANEL_ROWS)
    ) u_collect (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .blk       (blk),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready)
    );

    ptbr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk       (blk),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .pix_out   (pix_out)
    );

endmodule
